// File: hdl/tvts_pkg.sv
// Shared types, command codes and constants for the three-voice tone sequencer.
// No dependencies; the controller, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package tvts_pkg;

    // Defaults for the top-level parameters.
    localparam int NOTE_DEPTH_DEF      = 1024;
    localparam int SCALE_FRAC_BITS_DEF = 10;

    // Widest note address that the parameter range allows.
    localparam int NOTE_ADDR_MAX_W = 16;
    localparam int NOTE_WORD_W     = 32;

    // Command codes.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_MUSIC  = 3'd2;
    localparam logic [2:0] CMD_EFFECT = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GATE    = 2'd0;
    localparam logic [1:0] CFG_HDELAY  = 2'd1;
    localparam logic [1:0] CFG_RETRIG  = 2'd2;

    localparam logic [6:0]  GATE_RESET   = 7'd85;
    localparam logic [7:0]  HDELAY_RESET = 8'd2;
    localparam logic [3:0]  RETRIG_RESET = 4'd3;
    localparam logic [6:0]  GATE_MAX     = 7'd100;
    localparam logic [4:0]  NO_TRACK     = 5'd16;
    localparam logic [10:0] MAX_LEN      = 11'd1024;
    localparam logic [17:0] ELAPSED_MAX  = 18'h3FFFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  note_addr;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [10:0] seq_length;
        logic [10:0] main_scale;
        logic [10:0] second_scale;
        logic [3:0]  sound_id;
    } item_t;

    typedef struct packed {
        logic [15:0] tone_melody;
        logic [15:0] tone_harmony;
        logic [15:0] tone_effect;
        logic        effect_busy;
        logic        music_busy;
    } result_t;

    typedef struct packed {
        logic [6:0] gate_percent;
        logic [7:0] harmony_delay_ms;
        logic [3:0] retrigger_mask;
    } cfg_t;

    // One access to the note memory per cycle: a write and/or a read.
    typedef struct packed {
        logic                       we;
        logic [NOTE_ADDR_MAX_W-1:0] waddr;
        logic [NOTE_WORD_W-1:0]     wdata;
        logic                       re;
        logic [NOTE_ADDR_MAX_W-1:0] raddr;
    } ram_req_t;

    // Reduces a ten-bit address modulo the memory depth. The depth is at
    // least sixteen, so the quotient fits in six bits: six restoring steps.
    function automatic logic [31:0] note_wrap(input logic [31:0] value,
                                              input int unsigned depth);
        logic [31:0] r;
        r = value;
        for (int k = 5; k >= 0; k--) begin
            if (r >= 32'(depth << k))
            begin
                r = r - 32'(depth << k);
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/tvts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the note words of the sequencer.
`timescale 1ns / 1ps

module tvts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tvts_tone.sv
// Tone scaling unit: frequency times a fixed-point scale, saturated to 16 bits.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps

module tvts_tone #(
    parameter int SCALE_FRAC_BITS = 10
) (
    input  logic [15:0] freq,
    input  logic [10:0] scale,
    output logic [15:0] tone
);

    logic [26:0] prod;
    logic [26:0] shifted;

    assign prod    = 27'(freq) * 27'(scale);
    assign shifted = prod >> SCALE_FRAC_BITS;
    assign tone    = (|shifted[26:16]) ? 16'hFFFF : shifted[15:0];

endmodule

// File: hdl/tvts_ctrl.sv
// Voice state, command sequencer and result register of the tone sequencer.
// Depends on tvts_pkg and tvts_tone; drives the note memory through a request.
`timescale 1ns / 1ps

module tvts_ctrl #(
    parameter int NOTE_DEPTH      = tvts_pkg::NOTE_DEPTH_DEF,
    parameter int SCALE_FRAC_BITS = tvts_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tvts_pkg::cfg_t               cfg,
    input  logic                         item_valid,
    input  tvts_pkg::item_t              item,
    output logic                         pop,
    output tvts_pkg::ram_req_t           ram_req,
    input  logic [tvts_pkg::NOTE_WORD_W-1:0] ram_rdata,
    output logic                         result_valid,
    input  logic                         result_stall,
    output tvts_pkg::result_t            result
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(NOTE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Sequencer and status registers.
    logic [1:0]  state_reg, state_next;
    logic [1:0]  vsel_reg, vsel_next;
    logic        tickop_reg, tickop_next;
    logic        music_reg, music_next;
    logic [4:0]  track_reg, track_next;
    logic [3:0]  esound_reg, esound_next;
    logic        eactive_reg, eactive_next;
    logic [7:0]  hwait_reg, hwait_next;
    logic        res_valid_reg, res_valid_next;
    tvts_pkg::result_t res_reg, res_next;

    // Per-voice state.
    logic        playing_reg [3];
    logic        playing_next [3];
    logic [15:0] tone_reg [3];
    logic [15:0] tone_next [3];
    logic [AW-1:0] base_reg [3];
    logic [AW-1:0] base_next [3];
    logic [AW-1:0] addr_reg [3];
    logic [AW-1:0] addr_next [3];
    logic [9:0]  index_reg [3];
    logic [9:0]  index_next [3];
    logic [10:0] len_reg [3];
    logic [10:0] len_next [3];
    logic [17:0] elapsed_reg [3];
    logic [17:0] elapsed_next [3];
    logic [10:0] scale_reg [3];
    logic [10:0] scale_next [3];
    // Copy of the duration of the note at each voice's current address.
    logic [15:0] dur_reg [3];
    logic [15:0] dur_next [3];

    // Working values for the selected voice.
    logic [17:0] e_inc;
    logic [18:0] e_inc1;
    logic [25:0] gate_bound;
    logic [6:0]  gate_eff;
    logic [22:0] gate_prod;
    logic        silence;
    logic        advance;
    logic [10:0] idx1;
    logic        wrap_end;
    logic [AW:0] addr_sum;
    logic [AW-1:0] addr_inc;
    logic [15:0] tone_calc;
    logic [AW-1:0] item_addr;
    logic [10:0] len_clamp;
    logic        same_fx;
    logic        retrig;

    tvts_tone #(
        .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_tone (
        .freq  (ram_rdata[15:0]),
        .scale (scale_reg[vsel_reg]),
        .tone  (tone_calc)
    );

    always_comb
    begin
        e_inc = (elapsed_reg[vsel_reg] < tvts_pkg::ELAPSED_MAX)
              ? elapsed_reg[vsel_reg] + 18'd1 : elapsed_reg[vsel_reg];
        e_inc1 = {1'b0, e_inc} + 19'd1;
        gate_bound = 26'(e_inc1) * 26'd100;
        gate_eff = (cfg.gate_percent > tvts_pkg::GATE_MAX)
                 ? tvts_pkg::GATE_MAX : cfg.gate_percent;
        gate_prod = 23'(dur_reg[vsel_reg]) * 23'(gate_eff);
        // floor(d*g/100) <= e holds exactly when d*g < 100*(e+1).
        silence = 26'(gate_prod) < gate_bound;
        advance = e_inc >= {2'b00, dur_reg[vsel_reg]};
        idx1 = {1'b0, index_reg[vsel_reg]} + 11'd1;
        wrap_end = idx1 >= len_reg[vsel_reg];
        addr_sum = {1'b0, addr_reg[vsel_reg]} + (AW+1)'(1);
        addr_inc = (addr_sum == DEPTH_W) ? '0 : addr_sum[AW-1:0];
        item_addr = AW'(tvts_pkg::note_wrap(32'(item.note_addr), NOTE_DEPTH));
        len_clamp = (item.seq_length > tvts_pkg::MAX_LEN)
                  ? tvts_pkg::MAX_LEN : item.seq_length;
        same_fx = playing_reg[2] && eactive_reg
               && (esound_reg == item.sound_id);
        retrig = (item.sound_id[3:2] == 2'b00)
              && cfg.retrigger_mask[item.sound_id[1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        vsel_next      = vsel_reg;
        tickop_next    = tickop_reg;
        music_next     = music_reg;
        track_next     = track_reg;
        esound_next    = esound_reg;
        eactive_next   = eactive_reg;
        hwait_next     = hwait_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        playing_next   = playing_reg;
        tone_next      = tone_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        index_next     = index_reg;
        len_next       = len_reg;
        elapsed_next   = elapsed_reg;
        scale_next     = scale_reg;
        dur_next       = dur_reg;
        pop            = 1'b0;
        ram_req        = '0;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop = 1'b1;
                    state_next = ST_DONE;
                    unique case (item.cmd)
                        tvts_pkg::CMD_TICK:
                        begin
                            state_next = ST_TICK;
                            vsel_next  = 2'd0;
                        end
                        tvts_pkg::CMD_WRITE:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = tvts_pkg::NOTE_ADDR_MAX_W'(item_addr);
                            ram_req.wdata = {item.note_duration, item.note_freq};
                            // Keep each voice's note copy in step with the memory.
                            for (int v = 0; v < 3; v++)
                            begin
                                if (addr_reg[v] == item_addr)
                                begin
                                    dur_next[v]  = item.note_duration;
                                end
                            end
                        end
                        tvts_pkg::CMD_MUSIC:
                        begin
                            if (track_reg != {1'b0, item.sound_id})
                            begin
                                track_next = {1'b0, item.sound_id};
                                hwait_next = cfg.harmony_delay_ms;
                                for (int v = 0; v < 2; v++)
                                begin
                                    base_next[v]    = item_addr;
                                    addr_next[v]    = item_addr;
                                    index_next[v]   = '0;
                                    len_next[v]     = len_clamp;
                                    elapsed_next[v] = '0;
                                    playing_next[v] = 1'b1;
                                end
                                scale_next[0] = item.main_scale;
                                scale_next[1] = item.second_scale;
                                ram_req.re    = 1'b1;
                                ram_req.raddr = tvts_pkg::NOTE_ADDR_MAX_W'(item_addr);
                                vsel_next     = 2'd0;
                                music_next    = 1'b1;
                                tickop_next   = 1'b0;
                                state_next    = ST_LOAD;
                            end
                        end
                        tvts_pkg::CMD_EFFECT:
                        begin
                            if (!same_fx || retrig)
                            begin
                                esound_next     = item.sound_id;
                                eactive_next    = 1'b1;
                                base_next[2]    = item_addr;
                                addr_next[2]    = item_addr;
                                index_next[2]   = '0;
                                len_next[2]     = len_clamp;
                                elapsed_next[2] = '0;
                                scale_next[2]   = item.main_scale;
                                playing_next[2] = 1'b1;
                                ram_req.re      = 1'b1;
                                ram_req.raddr   = tvts_pkg::NOTE_ADDR_MAX_W'(item_addr);
                                vsel_next       = 2'd2;
                                music_next      = 1'b0;
                                tickop_next     = 1'b0;
                                state_next      = ST_LOAD;
                            end
                        end
                        tvts_pkg::CMD_STOP:
                        begin
                            playing_next[0] = 1'b0;
                            playing_next[1] = 1'b0;
                            tone_next[0]    = '0;
                            tone_next[1]    = '0;
                            hwait_next      = '0;
                            track_next      = tvts_pkg::NO_TRACK;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_TICK:
            begin
                // By default move on to the next voice.
                if (vsel_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    vsel_next = vsel_reg + 2'd1;
                end

                if (vsel_reg == 2'd1 && hwait_reg != 8'd0)
                begin
                    hwait_next = hwait_reg - 8'd1;
                end
                else if (playing_reg[vsel_reg])
                begin
                    elapsed_next[vsel_reg] = e_inc;
                    if (silence)
                    begin
                        tone_next[vsel_reg] = '0;
                    end
                    if (advance)
                    begin
                        if (wrap_end && vsel_reg == 2'd2)
                        begin
                            // The effect voice ends after its last note.
                            playing_next[2] = 1'b0;
                            tone_next[2]    = '0;
                        end
                        else
                        begin
                            index_next[vsel_reg]   = wrap_end ? 10'd0 : idx1[9:0];
                            addr_next[vsel_reg]    = wrap_end ? base_reg[vsel_reg]
                                                              : addr_inc;
                            elapsed_next[vsel_reg] = '0;
                            ram_req.re    = 1'b1;
                            ram_req.raddr = tvts_pkg::NOTE_ADDR_MAX_W'(
                                                wrap_end ? base_reg[vsel_reg] : addr_inc);
                            vsel_next   = vsel_reg;
                            tickop_next = 1'b1;
                            music_next  = 1'b0;
                            state_next  = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD:
            begin
                dur_next[vsel_reg]  = ram_rdata[31:16];
                tone_next[vsel_reg] = tone_calc;
                if (music_reg && vsel_reg == 2'd0)
                begin
                    // The harmony voice starts on the same word, still held.
                    vsel_next = 2'd1;
                end
                else if (tickop_reg && vsel_reg != 2'd2)
                begin
                    vsel_next  = vsel_reg + 2'd1;
                    state_next = ST_TICK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next        = 1'b1;
                    res_next.tone_melody  = tone_reg[0];
                    res_next.tone_harmony = tone_reg[1];
                    res_next.tone_effect  = tone_reg[2];
                    res_next.effect_busy  = playing_reg[2];
                    res_next.music_busy   = playing_reg[0] | playing_reg[1];
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vsel_reg      <= '0;
            tickop_reg    <= 1'b0;
            music_reg     <= 1'b0;
            track_reg     <= tvts_pkg::NO_TRACK;
            esound_reg    <= '0;
            eactive_reg   <= 1'b0;
            hwait_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int v = 0; v < 3; v++)
            begin
                playing_reg[v] <= 1'b0;
                tone_reg[v]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            vsel_reg      <= vsel_next;
            tickop_reg    <= tickop_next;
            music_reg     <= music_next;
            track_reg     <= track_next;
            esound_reg    <= esound_next;
            eactive_reg   <= eactive_next;
            hwait_reg     <= hwait_next;
            res_valid_reg <= res_valid_next;
            playing_reg   <= playing_next;
            tone_reg      <= tone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        base_reg    <= base_next;
        addr_reg    <= addr_next;
        index_reg   <= index_next;
        len_reg     <= len_next;
        elapsed_reg <= elapsed_next;
        scale_reg   <= scale_next;
        dur_reg     <= dur_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: hdl/three_voice_tone_sequencer_unit.sv
// Three-voice tone sequencer. An item waits in a one-beat input buffer, so the next
// beat is taken while a result still waits. Write, stop and ignored starts go to the
// result state; an effect start loads its first note, a music start the melody and
// then the harmony note; a tick visits each voice in turn, loading a new note for
// each voice moving on, all via the single read port. Reset (rst_n, asynchronous):
// voices silent, no track, registers at defaults; the note memory keeps its contents.
`timescale 1ns / 1ps

module three_voice_tone_sequencer_unit #(
    parameter int NOTE_DEPTH      = tvts_pkg::NOTE_DEPTH_DEF,
    parameter int SCALE_FRAC_BITS = tvts_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  tvts_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output tvts_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int AW = $clog2(NOTE_DEPTH);

    logic             buf_valid_reg, buf_valid_next;
    tvts_pkg::item_t  buf_reg, buf_next;
    tvts_pkg::cfg_t   cfg_reg, cfg_next;
    logic             pop;
    tvts_pkg::ram_req_t ram_req;
    logic [tvts_pkg::NOTE_WORD_W-1:0] ram_rdata;

    assign item_stall = buf_valid_reg;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_next       = buf_reg;
        if (item_valid && !buf_valid_reg)
        begin
            buf_valid_next = 1'b1;
            buf_next       = item;
        end
        else if (pop)
        begin
            buf_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tvts_pkg::CFG_GATE:   cfg_next.gate_percent     = cfg_data[6:0];
                tvts_pkg::CFG_HDELAY: cfg_next.harmony_delay_ms = cfg_data;
                tvts_pkg::CFG_RETRIG: cfg_next.retrigger_mask   = cfg_data[3:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg            <= 1'b0;
            cfg_reg.gate_percent     <= tvts_pkg::GATE_RESET;
            cfg_reg.harmony_delay_ms <= tvts_pkg::HDELAY_RESET;
            cfg_reg.retrigger_mask   <= tvts_pkg::RETRIG_RESET;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    tvts_ram #(
        .WIDTH (tvts_pkg::NOTE_WORD_W),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr[AW-1:0]),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr[AW-1:0]),
        .rdata (ram_rdata)
    );

    tvts_ctrl #(
        .NOTE_DEPTH      (NOTE_DEPTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (buf_valid_reg),
        .item         (buf_reg),
        .pop          (pop),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: tb/tb_three_voice_tone_sequencer_unit.sv
// Self-checking testbench for the three-voice tone sequencer: a scoreboard class models
// the voices and compares every result beat; plain tasks drive items and register writes.
// Depends on tvts_pkg and three_voice_tone_sequencer_unit.
`timescale 1ns / 1ps

class tone_scoreboard;
    logic [31:0] notes [tvts_pkg::NOTE_DEPTH_DEF];
    bit          voice_on [3];
    logic [9:0]  base [3];
    logic [9:0]  idx [3];
    logic [10:0] len [3];
    logic [17:0] elapsed [3];
    logic [10:0] scale [3];
    logic [15:0] tone [3];
    logic [4:0]  track;
    logic [3:0]  fx_sound;
    bit          fx_active;
    int unsigned hwait;
    logic [6:0]  gate;
    logic [7:0]  hdelay;
    logic [3:0]  retrig;
    tvts_pkg::result_t expected_q [$];
    int          errors;

    function new();
        foreach (notes[a])
        begin
            notes[a] = '0;
        end
        for (int v = 0; v < 3; v++)
        begin
            voice_on[v] = 1'b0;
            base[v]     = '0;
            idx[v]      = '0;
            len[v]      = '0;
            elapsed[v]  = '0;
            scale[v]    = '0;
            tone[v]     = '0;
        end
        track     = tvts_pkg::NO_TRACK;
        fx_sound  = '0;
        fx_active = 1'b0;
        hwait     = 0;
        gate      = tvts_pkg::GATE_RESET;
        hdelay    = tvts_pkg::HDELAY_RESET;
        retrig    = tvts_pkg::RETRIG_RESET;
        errors    = 0;
    endfunction

    function logic [31:0] note_at(int v);
        logic [9:0] a;
        a = base[v] + idx[v];
        return notes[a];
    endfunction

    function logic [15:0] scaled_tone(logic [15:0] freq, logic [10:0] sc);
        logic [26:0] p;
        p = (27'(freq) * 27'(sc)) >> tvts_pkg::SCALE_FRAC_BITS_DEF;
        return (p > 27'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function void stop_voice(int v);
        voice_on[v] = 1'b0;
        tone[v]     = '0;
    endfunction

    function void start_voice(int v, logic [9:0] addr, logic [10:0] count, logic [10:0] sc);
        logic [31:0] word;
        base[v]     = addr;
        idx[v]      = '0;
        len[v]      = (count > tvts_pkg::MAX_LEN) ? tvts_pkg::MAX_LEN : count;
        elapsed[v]  = '0;
        scale[v]    = sc;
        voice_on[v] = 1'b1;
        word        = note_at(v);
        tone[v]     = scaled_tone(word[15:0], sc);
    endfunction

    function void silence_music();
        stop_voice(0);
        stop_voice(1);
        hwait = 0;
        track = tvts_pkg::NO_TRACK;
    endfunction

    function void tick_voice(int v, bit looping);
        logic [31:0] word;
        int unsigned dur;
        int unsigned lim;
        int unsigned nxt;
        if (!voice_on[v])
        begin
            return;
        end
        word = note_at(v);
        dur  = word[31:16];
        lim  = (gate > tvts_pkg::GATE_MAX) ? tvts_pkg::GATE_MAX : gate;
        if (elapsed[v] < tvts_pkg::ELAPSED_MAX)
        begin
            elapsed[v]++;
        end
        if (elapsed[v] >= (dur * lim) / 100)
        begin
            tone[v] = '0;
        end
        if (elapsed[v] >= dur)
        begin
            nxt = idx[v] + 1;
            if (nxt >= len[v])
            begin
                if (!looping)
                begin
                    stop_voice(v);
                    return;
                end
                nxt = 0;
            end
            idx[v]     = nxt[9:0];
            word       = note_at(v);
            tone[v]    = scaled_tone(word[15:0], scale[v]);
            elapsed[v] = '0;
        end
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] data);
        case (index)
            tvts_pkg::CFG_GATE:   gate   = data[6:0];
            tvts_pkg::CFG_HDELAY: hdelay = data;
            tvts_pkg::CFG_RETRIG: retrig = data[3:0];
            default: ;
        endcase
    endfunction

    // Applies one accepted item to the voice state and queues the tones it leaves.
    function void note_item(tvts_pkg::item_t it);
        bit same;
        bit retrig_ok;
        tvts_pkg::result_t r;
        case (it.cmd)
            tvts_pkg::CMD_TICK:
            begin
                tick_voice(0, 1'b1);
                if (hwait > 0)
                begin
                    hwait--;
                end
                else
                begin
                    tick_voice(1, 1'b1);
                end
                tick_voice(2, 1'b0);
            end
            tvts_pkg::CMD_WRITE:
            begin
                notes[it.note_addr] = {it.note_duration, it.note_freq};
            end
            tvts_pkg::CMD_MUSIC:
            begin
                if ({1'b0, it.sound_id} != track)
                begin
                    silence_music();
                    track = {1'b0, it.sound_id};
                    start_voice(0, it.note_addr, it.seq_length, it.main_scale);
                    start_voice(1, it.note_addr, it.seq_length, it.second_scale);
                    hwait = hdelay;
                end
            end
            tvts_pkg::CMD_EFFECT:
            begin
                same      = voice_on[2] && fx_active && (fx_sound == it.sound_id);
                retrig_ok = (it.sound_id < 4) && retrig[it.sound_id[1:0]];
                if (!same || retrig_ok)
                begin
                    fx_sound  = it.sound_id;
                    fx_active = 1'b1;
                    start_voice(2, it.note_addr, it.seq_length, it.main_scale);
                end
            end
            tvts_pkg::CMD_STOP:
            begin
                silence_music();
            end
            default: ;
        endcase
        r = {tone[0], tone[1], tone[2], voice_on[2], voice_on[0] | voice_on[1]};
        expected_q.push_back(r);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch %0d: %s", errors, msg);
    endtask

    task check_result(tvts_pkg::result_t got);
        tvts_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result beat %h arrived with nothing expected", got));
            return;
        end
        want = expected_q.pop_front();
        if (got.tone_melody !== want.tone_melody)
        begin
            report($sformatf("tone_melody %0d, expected %0d", got.tone_melody,
                             want.tone_melody));
        end
        if (got.tone_harmony !== want.tone_harmony)
        begin
            report($sformatf("tone_harmony %0d, expected %0d", got.tone_harmony,
                             want.tone_harmony));
        end
        if (got.tone_effect !== want.tone_effect)
        begin
            report($sformatf("tone_effect %0d, expected %0d", got.tone_effect,
                             want.tone_effect));
        end
        if (got.effect_busy !== want.effect_busy)
        begin
            report($sformatf("effect_busy %b, expected %b", got.effect_busy,
                             want.effect_busy));
        end
        if (got.music_busy !== want.music_busy)
        begin
            report($sformatf("music_busy %b, expected %b", got.music_busy,
                             want.music_busy));
        end
    endtask
endclass

module tb_three_voice_tone_sequencer_unit;

    localparam int NOTE_WORDS   = tvts_pkg::NOTE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // Command codes the block must ignore.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    tvts_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    tvts_pkg::result_t result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index    = '0;
    logic [7:0]        cfg_data     = '0;

    tone_scoreboard sb;
    bit          stored [NOTE_WORDS];
    bit          calm         = 1'b0;
    int          beats_sent   = 0;
    int unsigned cycles       = 0;
    logic [3:0]  last_track   = '0;
    logic [3:0]  last_fx      = '0;

    three_voice_tone_sequencer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side: stalls come in bursts, and no new burst starts in a calm phase.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && !calm && $urandom_range(0, 99) < 25)
            begin
                hold_left = gap_len();
            end
            if (hold_left > 0)
            begin
                result_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall = 1'b0;
            end
        end
    end

    // Entered and left at a falling edge; valid stays high if the next beat follows at once.
    task automatic send_item(input tvts_pkg::item_t it);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 25) ? gap_len() : 0;
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
        if (it.cmd == tvts_pkg::CMD_WRITE)
        begin
            stored[it.note_addr] = 1'b1;
        end
        if (it.cmd <= tvts_pkg::CMD_STOP)
        begin
            beats_sent++;
        end
        @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] data);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        item_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    function automatic tvts_pkg::item_t make_item(input logic [2:0] cmd,
                                                  input logic [9:0] addr,
                                                  input logic [15:0] freq,
                                                  input logic [15:0] dur,
                                                  input logic [10:0] count,
                                                  input logic [10:0] ms,
                                                  input logic [10:0] ss,
                                                  input logic [3:0] id);
        tvts_pkg::item_t it;
        it.cmd           = cmd;
        it.note_addr     = addr;
        it.note_freq     = freq;
        it.note_duration = dur;
        it.seq_length    = count;
        it.main_scale    = ms;
        it.second_scale  = ss;
        it.sound_id      = id;
        return it;
    endfunction

    function automatic tvts_pkg::item_t random_item();
        logic [95:0] raw;
        tvts_pkg::item_t it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(tvts_pkg::item_t)-1:0];
        return it;
    endfunction

    function automatic logic [15:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 80) return 16'($urandom_range(100, 3000));
        if (r < 90) return 16'($urandom_range(30000, 65535));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly short notes so that sequences move on; a rare one is very long.
    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 75) return 16'($urandom_range(1, 8));
        if (r < 98) return 16'($urandom_range(9, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [10:0] pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'd0;
        if (r < 20) return 11'd1024;
        if (r < 75) return 11'($urandom_range(256, 1024));
        if (r < 90) return 11'($urandom_range(1025, 2047));
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic logic [10:0] pick_length();
        int r;
        r = $urandom_range(0, 199);
        if (r < 20) return 11'd0;
        if (r < 150) return 11'($urandom_range(1, 6));
        if (r < 186) return 11'($urandom_range(7, 40));
        if (r < 194) return 11'($urandom_range(41, 200));
        if (r < 197) return 11'($urandom_range(1024, 2047));
        return 11'($urandom_range(201, 1023));
    endfunction

    function automatic logic [9:0] pick_addr();
        if ($urandom_range(0, 99) < 60) return 10'($urandom_range(0, 31));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic tvts_pkg::item_t note_write(input logic [9:0] a);
        tvts_pkg::item_t it;
        it               = random_item();
        it.cmd           = tvts_pkg::CMD_WRITE;
        it.note_addr     = a;
        it.note_freq     = pick_freq();
        it.note_duration = pick_duration();
        return it;
    endfunction

    // Every note that a start can reach is written first, so no empty word is ever read.
    task automatic fill_span(input logic [9:0] addr, input logic [10:0] count);
        int span;
        logic [9:0] a;
        span = (count == 0) ? 1 : ((count > tvts_pkg::MAX_LEN) ? int'(tvts_pkg::MAX_LEN)
                                                              : int'(count));
        for (int i = 0; i < span; i++)
        begin
            a = addr + 10'(i);
            if (!stored[a])
            begin
                send_item(note_write(a));
            end
        end
    endtask

    task automatic random_beat();
        tvts_pkg::item_t it;
        int r;
        it = random_item();
        r  = $urandom_range(0, 99);
        if (r < 55)
        begin
            it.cmd = tvts_pkg::CMD_TICK;
        end
        else if (r < 67)
        begin
            it = note_write(pick_addr());
        end
        else if (r < 78)
        begin
            it.cmd          = tvts_pkg::CMD_MUSIC;
            it.note_addr    = pick_addr();
            it.seq_length   = pick_length();
            it.main_scale   = pick_scale();
            it.second_scale = pick_scale();
            it.sound_id     = ($urandom_range(0, 99) < 30) ? last_track
                                                           : 4'($urandom_range(0, 15));
            last_track      = it.sound_id;
            fill_span(it.note_addr, it.seq_length);
        end
        else if (r < 92)
        begin
            it.cmd        = tvts_pkg::CMD_EFFECT;
            it.note_addr  = pick_addr();
            it.seq_length = pick_length();
            it.main_scale = pick_scale();
            r             = $urandom_range(0, 99);
            if (r < 40)
            begin
                it.sound_id = last_fx;
            end
            else if (r < 80)
            begin
                it.sound_id = 4'($urandom_range(0, 5));
            end
            else
            begin
                it.sound_id = 4'($urandom_range(0, 15));
            end
            last_fx = it.sound_id;
            fill_span(it.note_addr, it.seq_length);
        end
        else if (r < 96)
        begin
            it.cmd = tvts_pkg::CMD_STOP;
        end
        else
        begin
            it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        send_item(it);
    endtask

    task automatic configure(input int ph);
        logic [7:0] g;
        logic [7:0] h;
        logic [7:0] m;
        case (ph)
            0:
            begin
                g = 8'd0;
                h = 8'd0;
                m = 8'h00;
            end
            1:
            begin
                g = 8'(tvts_pkg::GATE_MAX);
                h = 8'hFF;
                m = 8'h0F;
            end
            2:
            begin
                g = 8'd127;
                h = 8'd1;
                m = 8'h05;
            end
            default:
            begin
                g = 8'($urandom_range(0, 130));
                h = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 10));
                m = 8'($urandom_range(0, 255));
            end
        endcase
        write_register(tvts_pkg::CFG_GATE, g);
        write_register(tvts_pkg::CFG_HDELAY, h);
        write_register(tvts_pkg::CFG_RETRIG, m);
    endtask

    task automatic directed();
        tvts_pkg::item_t tick_beat;
        tick_beat = make_item(tvts_pkg::CMD_TICK, 10'd0, 16'd0, 16'd0, 11'd0, 11'd0,
                              11'd0, 4'd0);
        send_item(make_item(tvts_pkg::CMD_WRITE, 10'd0, 16'd440, 16'd3, 11'd0, 11'd0,
                            11'd0, 4'd0));
        // A rest, then a zero-length note at the top frequency.
        send_item(make_item(tvts_pkg::CMD_WRITE, 10'd1, 16'd0, 16'd2, 11'd0, 11'd0,
                            11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_WRITE, 10'd2, 16'hFFFF, 16'd0, 11'd0, 11'd0,
                            11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_WRITE, 10'd3, 16'd300, 16'd1, 11'd0, 11'd0,
                            11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_WRITE, 10'h3FF, 16'd1000, 16'd4, 11'd0, 11'd0,
                            11'd0, 4'd0));
        send_item(tick_beat);
        // The sequence runs off the top of the memory and wraps to address 0.
        send_item(make_item(tvts_pkg::CMD_MUSIC, 10'h3FF, 16'd0, 16'd0, 11'd3, 11'd1024,
                            11'd512, 4'd5));
        send_item(make_item(tvts_pkg::CMD_MUSIC, 10'd0, 16'd0, 16'd0, 11'd2, 11'd700,
                            11'd700, 4'd5));
        repeat (4) send_item(tick_beat);
        // Full-scale gain on the top frequency saturates the tone.
        send_item(make_item(tvts_pkg::CMD_EFFECT, 10'd2, 16'd0, 16'd0, 11'd2, 11'd2047,
                            11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_EFFECT, 10'd3, 16'd0, 16'd0, 11'd1, 11'd1024,
                            11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_EFFECT, 10'd0, 16'd0, 16'd0, 11'd0, 11'd1024,
                            11'd0, 4'd7));
        send_item(make_item(tvts_pkg::CMD_EFFECT, 10'd1, 16'd0, 16'd0, 11'd1, 11'd1024,
                            11'd0, 4'd7));
        repeat (3) send_item(tick_beat);
        send_item(make_item(tvts_pkg::CMD_STOP, 10'd0, 16'd0, 16'd0, 11'd0, 11'd0,
                            11'd0, 4'd0));
        send_item(make_item(CMD_SPARE_LO, 10'h3FF, 16'hFFFF, 16'hFFFF, 11'h7FF, 11'h7FF,
                            11'h7FF, 4'hF));
        send_item(make_item(CMD_SPARE_HI, 10'd0, 16'd0, 16'd0, 11'd0, 11'd0, 11'd0, 4'd0));
        send_item(make_item(tvts_pkg::CMD_MUSIC, 10'd0, 16'd0, 16'd0, 11'd0, 11'd0,
                            11'd1024, 4'd15));
        repeat (2) send_item(tick_beat);
    endtask

    initial
    begin
        int target;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            configure(ph);
            calm   = (ph == 3);
            target = beats_sent + RANDOM_ITEMS / PHASES;
            while (beats_sent < target)
            begin
                random_beat();
            end
        end
        settle();
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/tvts_pkg.sv
hdl/tvts_ram.sv
hdl/tvts_tone.sv
hdl/tvts_ctrl.sv
hdl/three_voice_tone_sequencer_unit.sv
tb/tb_three_voice_tone_sequencer_unit.sv
